// ===== rtl/grbs_pkg.sv =====
// shared types and constants for the glyph row blitter
`default_nettype none

package grbs_pkg;

  // register and field widths
  localparam int unsigned CFG_W      = 13;
  localparam int unsigned ADDR_W     = 24;
  localparam int unsigned BITS_W     = 16;
  localparam int unsigned COORD_W    = 12;
  localparam int unsigned ROWNUM_W   = 4;
  localparam int unsigned COLOR_W    = 8;
  localparam int unsigned COL_IDX_W  = 4;
  localparam int unsigned NARROW_COLS = 8;
  localparam int unsigned APB_ADDR_W = 3;
  localparam int unsigned APB_DATA_W = 32;

  // register map, index taken from the word address
  localparam logic REG_SCREEN_WIDTH  = 1'b0;
  localparam logic REG_SCREEN_HEIGHT = 1'b1;

  localparam logic [CFG_W-1:0] SCREEN_WIDTH_RST  = 13'd320;
  localparam logic [CFG_W-1:0] SCREEN_HEIGHT_RST = 13'd200;

  // queue between front and back
  localparam int unsigned FIFO_DEPTH = 2;
  localparam int unsigned FIFO_PTR_W = 1;
  localparam int unsigned FIFO_CNT_W = 2;

  typedef struct packed {
    logic [BITS_W-1:0]   row_bits;
    logic                wide;
    logic [COORD_W-1:0]  origin_x;
    logic [COORD_W-1:0]  origin_y;
    logic [ROWNUM_W-1:0] row_number;
    logic [COLOR_W-1:0]  color;
    logic                shadow;
  } grbs_in_t;

  typedef struct packed {
    logic [ADDR_W-1:0]  pixel_address;
    logic [COLOR_W-1:0] pixel_value;
    logic               last;
  } grbs_out_t;

  // one classified row, ready for the write sequencer
  typedef struct packed {
    logic [BITS_W-1:0]  lit;
    logic [BITS_W-1:0]  right_ok;
    logic [COORD_W-1:0] origin_x;
    logic [ADDR_W-1:0]  base;
    logic [CFG_W-1:0]   width;
    logic [COLOR_W-1:0] color;
    logic               shadow;
    logic               below_ok;
  } grbs_job_t;

  typedef enum logic [1:0] {
    PH_COLOUR,
    PH_RIGHT,
    PH_BELOW,
    PH_BELOW_RIGHT
  } grbs_phase_e;

endpackage

`default_nettype wire

// ===== rtl/grbs_front.sv =====
// front end: takes row transactions, clips them and computes the row base address
`default_nettype none

module grbs_front import grbs_pkg::*; #(
  parameter int unsigned MAX_SCREEN_WIDTH  = 4096,
  parameter int unsigned MAX_SCREEN_HEIGHT = 4096
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic [CFG_W-1:0] screen_width_i,
  input  wire logic [CFG_W-1:0] screen_height_i,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire grbs_in_t         in_data_i,
  input  wire logic             fifo_full_i,
  output logic                  push_o,
  output grbs_job_t             job_o
);

  localparam logic [CFG_W-1:0] MaxW = CFG_W'(MAX_SCREEN_WIDTH);
  localparam logic [CFG_W-1:0] MaxH = CFG_W'(MAX_SCREEN_HEIGHT);

  logic                 item_valid_q, item_valid_d;
  grbs_in_t             item_q;
  logic [CFG_W-1:0]     w_sat, h_sat, row, max_cols;
  logic [BITS_W-1:0]    lit, right_ok;
  logic [2*CFG_W-1:0]   prod;
  logic                 drop, consume;

  // saturate the registers to the supported screen size
  assign w_sat = (screen_width_i  > MaxW) ? MaxW : screen_width_i;
  assign h_sat = (screen_height_i > MaxH) ? MaxH : screen_height_i;

  // clipping and per-column masks
  assign row      = CFG_W'(item_q.origin_y) + CFG_W'(item_q.row_number);
  assign max_cols = w_sat - CFG_W'(item_q.origin_x);

  always_comb begin
    lit      = '0;
    right_ok = '0;
    for (int j = 0; j < BITS_W; j++) begin
      lit[j] = item_q.row_bits[j] && (CFG_W'(j) < max_cols) &&
               ((j < NARROW_COLS) || item_q.wide);
      right_ok[j] = CFG_W'(j + 1) < max_cols;
    end
  end

  assign drop = (CFG_W'(item_q.origin_x) >= w_sat) || (row >= h_sat) || (lit == '0);
  assign prod = row * w_sat;

  // classified job towards the queue
  always_comb begin
    job_o.lit        = lit;
    job_o.right_ok   = right_ok;
    job_o.origin_x   = item_q.origin_x;
    job_o.base       = prod[ADDR_W-1:0];
    job_o.width      = w_sat;
    job_o.color      = item_q.color;
    job_o.shadow     = item_q.shadow;
    job_o.below_ok   = (row + CFG_W'(1)) < h_sat;
  end

  assign consume    = item_valid_q && (drop || !fifo_full_i);
  assign push_o     = item_valid_q && !drop && !fifo_full_i;
  assign in_ready_o = !item_valid_q || consume;

  // input holding register
  always_comb begin
    item_valid_d = item_valid_q;
    if (consume) begin
      item_valid_d = 1'b0;
    end
    if (in_valid_i && in_ready_o) begin
      item_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q <= 1'b0;
    end else begin
      item_valid_q <= item_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q <= in_data_i;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/grbs_fifo.sv =====
// short job queue between front and back
`default_nettype none

module grbs_fifo import grbs_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      push_i,
  input  wire grbs_job_t wdata_i,
  input  wire logic      pop_i,
  output grbs_job_t      rdata_o,
  output logic           full_o,
  output logic           empty_o
);

  grbs_job_t               mem_q [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0]   wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [FIFO_CNT_W-1:0]   count_q, count_d;

  assign full_o  = count_q == FIFO_CNT_W'(FIFO_DEPTH);
  assign empty_o = count_q == '0;
  assign rdata_o = mem_q[rd_ptr_q];

  // pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

`ifndef NO_ASSERTIONS
  assert property (@(posedge clk_i) disable iff (!rst_ni) !(push_i && full_o))
    else $error("job queue overflow");
  assert property (@(posedge clk_i) disable iff (!rst_ni) !(pop_i && empty_o))
    else $error("job queue underflow");
`endif

endmodule

`default_nettype wire

// ===== rtl/grbs_back.sv =====
// back end: walks lit columns and emits colour and shadow pixel writes
`default_nettype none

module grbs_back import grbs_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire grbs_job_t job_i,
  input  wire logic      fifo_empty_i,
  output logic           pop_o,
  output logic           out_valid_o,
  input  wire logic      out_ready_i,
  output grbs_out_t      out_data_o
);

  logic                  busy_q, busy_d;
  grbs_phase_e           phase_q, phase_d;
  logic [BITS_W-1:0]     mask_q, mask_d, mask_rest;
  grbs_job_t             job_q;
  logic [ADDR_W-1:0]     below_q, row_base;
  logic                  out_valid_q, out_valid_d;
  grbs_out_t             out_q, out_d;
  logic [COL_IDX_W-1:0]  col;
  logic                  emit, has_right, has_below, has_br, col_done, is_last;
  logic [CFG_W-1:0]      colx;

  // lowest lit column still to do
  always_comb begin
    col = '0;
    for (int j = BITS_W - 1; j >= 0; j--) begin
      if (mask_q[j]) begin
        col = COL_IDX_W'(j);
      end
    end
  end

  assign mask_rest = mask_q & (mask_q - 1'b1);
  assign has_right = job_q.shadow && job_q.right_ok[col];
  assign has_below = job_q.shadow && job_q.below_ok;
  assign has_br    = has_right && job_q.below_ok;

  assign emit  = busy_q && (!out_valid_q || out_ready_i);
  assign pop_o = !busy_q && !fifo_empty_i;

  // write address of the current phase
  assign row_base = ((phase_q == PH_BELOW) || (phase_q == PH_BELOW_RIGHT)) ? below_q
                                                                            : job_q.base;
  assign colx = CFG_W'(job_q.origin_x) + CFG_W'(col) +
                CFG_W'((phase_q == PH_RIGHT) || (phase_q == PH_BELOW_RIGHT));

  // sequencer: next phase, column mask and output register
  always_comb begin
    phase_d     = phase_q;
    col_done    = 1'b0;
    mask_d      = mask_q;
    busy_d      = busy_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;

    unique case (phase_q)
      PH_COLOUR: begin
        if (has_right) begin
          phase_d = PH_RIGHT;
        end else if (has_below) begin
          phase_d = PH_BELOW;
        end else begin
          col_done = 1'b1;
        end
      end
      PH_RIGHT: begin
        if (has_below) begin
          phase_d = PH_BELOW;
        end else begin
          col_done = 1'b1;
        end
      end
      PH_BELOW: begin
        if (has_br) begin
          phase_d = PH_BELOW_RIGHT;
        end else begin
          col_done = 1'b1;
        end
      end
      PH_BELOW_RIGHT: begin
        col_done = 1'b1;
      end
    endcase
    is_last = col_done && (mask_rest == '0);

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    if (pop_o) begin
      busy_d  = 1'b1;
      mask_d  = job_i.lit;
      phase_d = PH_COLOUR;
    end else if (emit) begin
      out_valid_d         = 1'b1;
      out_d.pixel_address = row_base + ADDR_W'(colx);
      out_d.pixel_value   = (phase_q == PH_COLOUR) ? job_q.color : '0;
      out_d.last          = is_last;
      if (col_done) begin
        mask_d  = mask_rest;
        phase_d = PH_COLOUR;
      end
      if (is_last) begin
        busy_d = 1'b0;
      end
    end else begin
      phase_d = phase_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      phase_q     <= PH_COLOUR;
      mask_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      phase_q     <= phase_d;
      mask_q      <= mask_d;
      out_valid_q <= out_valid_d;
    end
  end

  // job and result payload
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      job_q   <= job_i;
      below_q <= job_i.base + ADDR_W'(job_i.width);
    end
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef NO_ASSERTIONS
  assert property (@(posedge clk_i) disable iff (!rst_ni) busy_q |-> (mask_q != '0))
    else $error("sequencer busy with no columns left");
  assert property (@(posedge clk_i) disable iff (!rst_ni) (emit && is_last) |=> !busy_q)
    else $error("sequencer still busy after final write");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (busy_q && (phase_q != PH_COLOUR)) |-> job_q.shadow)
    else $error("shadow phase without shadow");
`endif

endmodule

`default_nettype wire

// ===== rtl/glyph_row_blit_with_shadow_unit.sv =====
// top level of the glyph row blitter: register file, front, queue and back
//
//  channel   direction  handshake            payload
//  in        input      in_valid / in_ready  grbs_in_t  (one glyph row)
//  out       output     out_valid/out_ready  grbs_out_t (one pixel write)
//  apb       input      psel/penable/pready  screen_width, screen_height
//
//  An item gives 0 to 64 pixel writes from the back sequencer, one per cycle unless the
//  output stalls, after the job is loaded from the queue; the column walk sets the rate.
//  Items that give no write are dropped by the front.
//  The front computes row base with one multiply and queues up to two jobs.
//  Reset clears all control state and sets width 320, height 200.
//  A stalled output holds the sequencer; the front keeps accepting until the queue fills.
`default_nettype none

module glyph_row_blit_with_shadow_unit import grbs_pkg::*; #(
  parameter int unsigned MAX_SCREEN_WIDTH  = 4096,
  parameter int unsigned MAX_SCREEN_HEIGHT = 4096
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  input  wire grbs_in_t              in_data_i,
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  output grbs_out_t                  out_data_o,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [APB_ADDR_W-1:0] paddr,
  input  wire logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0]      prdata,
  output logic                       pready
);

  logic [CFG_W-1:0] screen_width_q, screen_height_q;
  logic             reg_wr, fifo_full, fifo_empty, push, pop;
  grbs_job_t        job_in, job_out;

  // configuration registers
  assign pready = 1'b1;
  assign reg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      screen_width_q  <= SCREEN_WIDTH_RST;
      screen_height_q <= SCREEN_HEIGHT_RST;
    end else if (reg_wr) begin
      if (paddr[2] == REG_SCREEN_WIDTH) begin
        screen_width_q <= pwdata[CFG_W-1:0];
      end else begin
        screen_height_q <= pwdata[CFG_W-1:0];
      end
    end
  end

  assign prdata = (paddr[2] == REG_SCREEN_WIDTH) ? APB_DATA_W'(screen_width_q)
                                                  : APB_DATA_W'(screen_height_q);

  // front end
  grbs_front #(
    .MAX_SCREEN_WIDTH  (MAX_SCREEN_WIDTH),
    .MAX_SCREEN_HEIGHT (MAX_SCREEN_HEIGHT)
  ) u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .screen_width_i  (screen_width_q),
    .screen_height_i (screen_height_q),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .in_data_i       (in_data_i),
    .fifo_full_i     (fifo_full),
    .push_o          (push),
    .job_o           (job_in)
  );

  // job queue
  grbs_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (job_in),
    .pop_i   (pop),
    .rdata_o (job_out),
    .full_o  (fifo_full),
    .empty_o (fifo_empty)
  );

  // back end
  grbs_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .job_i        (job_out),
    .fifo_empty_i (fifo_empty),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_data_o   (out_data_o)
  );

endmodule

`default_nettype wire
